FILE: design/assert_macros.svh
// assertion helpers shared by the rtl, clocked on aclk and muted in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/ptrt_pkg.sv
`default_nettype none

package ptrt_pkg;

    localparam int ID_W       = 16;
    localparam int TIME_W     = 32;
    localparam int ATT_W      = 4;
    localparam int RES_W      = 4;
    localparam int FUNC_W     = 3;
    localparam int PCNT_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_ADD     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CONFIRM = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SCAN    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

    // event codes
    localparam logic [RES_W-1:0] EV_ADDED       = 4'd0;
    localparam logic [RES_W-1:0] EV_FULL        = 4'd1;
    localparam logic [RES_W-1:0] EV_CONFIRMED   = 4'd2;
    localparam logic [RES_W-1:0] EV_NOT_PENDING = 4'd3;
    localparam logic [RES_W-1:0] EV_RETRY       = 4'd4;
    localparam logic [RES_W-1:0] EV_DROPPED     = 4'd5;
    localparam logic [RES_W-1:0] EV_PRESENT     = 4'd6;
    localparam logic [RES_W-1:0] EV_SCAN_DONE   = 4'd7;
    localparam logic [RES_W-1:0] EV_CLEARED     = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIES = 1'b1;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd120000;
    localparam logic [ATT_W-1:0]  RETRIES_RST = 4'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
        logic [ATT_W-1:0]  att;
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

`default_nettype wire

FILE: design/pending_transfer_retry_table_core.sv
`default_nettype none
`include "assert_macros.svh"

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------------
// s_        | in        | s_tvalid/s_tready  | s_tuser func, s_tdata entry_id, now_ms
// m_        | out       | m_tvalid/m_tready  | m_tuser event_res, m_tdata id/att/count
// cfg_      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// add, confirm, query, scan: a walk over every slot with one registered slot read and one
// shared age / id compare per cycle while not stalled, then the final result is loaded into
// the output register and the block returns to idle; clear: final result only; unknown func: no result
// each scan event the sink does not take stalls the walk; the next transaction is still
// accepted while the final result waits in the output register
// aresetn (synchronous) empties the table and restores register defaults

module pending_transfer_retry_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ptrt_pkg::IN_DATA_W-1:0]   s_tdata,   // entry_id, now_ms
    input  wire logic [ptrt_pkg::FUNC_W-1:0]      s_tuser,   // func
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ptrt_pkg::OUT_DATA_W-1:0]       m_tdata,   // event_id, attempt_count,
                                                             // entry count, zero pad
    output logic [ptrt_pkg::RES_W-1:0]            m_tuser,   // event_res
    output logic                                  m_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ptrt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ptrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import ptrt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // slot memory, one write and one registered read per cycle
    slot_t slot_mem [TABLE_DEPTH];

    state_t                  state_reg, state_next;
    logic [FUNC_W-1:0]       func_reg, func_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic [TIME_W-1:0]       timeout_reg, timeout_next;
    logic [ATT_W-1:0]        retries_reg, retries_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    // walk pipeline: a stage issues the read, b stage evaluates the slot
    logic [IDX_W-1:0]        a_idx_reg, a_idx_next;
    logic                    a_busy_reg, a_busy_next;
    logic [IDX_W-1:0]        b_idx_reg, b_idx_next;
    logic                    b_busy_reg, b_busy_next;
    slot_t                   rd_slot_reg;

    // search results for add / confirm / query
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [ATT_W-1:0]        hit_att_reg, hit_att_next;
    logic                    free_reg, free_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [RES_W-1:0]        out_res_reg, out_res_next;
    logic [ID_W-1:0]         out_id_reg, out_id_next;
    logic [ATT_W-1:0]        out_att_reg, out_att_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;
    logic                    out_last_reg, out_last_next;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wa;
    slot_t                   mem_wd;
    logic                    rd_en;
    logic                    out_free;
    logic                    out_load;
    logic                    stall;
    logic                    b_vld;
    logic [TIME_W-1:0]       age;
    logic                    timed_out;
    logic                    can_retry;
    logic                    id_eq;

    // shared evaluation unit on the slot in the b stage
    assign b_vld     = valid_reg[b_idx_reg];
    assign age       = now_reg - rd_slot_reg.stamp;
    assign timed_out = b_vld && (age > timeout_reg);
    assign can_retry = rd_slot_reg.att < retries_reg;
    assign id_eq     = b_vld && (rd_slot_reg.id == id_reg);
    assign out_free  = !out_valid_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_res_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {3'b000, PCNT_W'(out_cnt_reg), out_att_reg, out_id_reg};

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        timeout_next   = timeout_reg;
        retries_next   = retries_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        a_idx_next     = a_idx_reg;
        a_busy_next    = a_busy_reg;
        b_idx_next     = b_idx_reg;
        b_busy_next    = b_busy_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_att_next   = hit_att_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_id_next    = out_id_reg;
        out_att_next   = out_att_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_wa         = b_idx_reg;
        mem_wd         = rd_slot_reg;
        rd_en          = 1'b0;
        out_load       = 1'b0;
        stall          = 1'b0;

        // sink took the waiting result
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // register writes are for the user to send only while idle; the block itself does not enforce it
        if (cfg_valid) begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_next = cfg_data;
                CFG_RETRIES: retries_next = cfg_data[ATT_W-1:0];
                default:     timeout_next = timeout_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next   = s_tuser;
                    id_next     = s_tdata[ID_W-1:0];
                    now_next    = s_tdata[ID_W +: TIME_W];
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    a_idx_next  = '0;
                    a_busy_next = 1'b1;
                    b_busy_next = 1'b0;
                    if (s_tuser == FN_ADD || s_tuser == FN_CONFIRM ||
                        s_tuser == FN_SCAN || s_tuser == FN_QUERY) begin
                        state_next = ST_WALK;
                    end else if (s_tuser == FN_CLEAR) begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_WALK: begin
                if (b_busy_reg) begin
                    if (func_reg == FN_SCAN) begin
                        if (timed_out) begin
                            if (!out_free) begin
                                stall = 1'b1;
                            end else begin
                                out_load      = 1'b1;
                                out_id_next   = rd_slot_reg.id;
                                out_last_next = 1'b0;
                                if (can_retry) begin
                                    mem_we       = 1'b1;
                                    mem_wa       = b_idx_reg;
                                    mem_wd.id    = rd_slot_reg.id;
                                    mem_wd.stamp = now_reg;
                                    mem_wd.att   = rd_slot_reg.att + ATT_W'(1);
                                    out_res_next = EV_RETRY;
                                    out_att_next = rd_slot_reg.att + ATT_W'(1);
                                    out_cnt_next = cnt_reg;
                                end else begin
                                    valid_next[b_idx_reg] = 1'b0;
                                    cnt_next     = cnt_reg - CNT_W'(1);
                                    out_res_next = EV_DROPPED;
                                    out_att_next = '0;
                                    out_cnt_next = cnt_reg - CNT_W'(1);
                                end
                            end
                        end
                    end else begin
                        if (id_eq && !hit_reg) begin
                            hit_next     = 1'b1;
                            hit_idx_next = b_idx_reg;
                            hit_att_next = rd_slot_reg.att;
                        end
                        if (!b_vld && !free_reg) begin
                            free_next     = 1'b1;
                            free_idx_next = b_idx_reg;
                        end
                    end
                end

                if (!stall) begin
                    if (a_busy_reg) begin
                        rd_en       = 1'b1;
                        b_idx_next  = a_idx_reg;
                        b_busy_next = 1'b1;
                        if (a_idx_reg == LAST_IDX) begin
                            a_busy_next = 1'b0;
                        end else begin
                            a_idx_next = a_idx_reg + IDX_W'(1);
                        end
                    end else begin
                        b_busy_next = 1'b0;
                        state_next  = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    out_id_next   = id_reg;
                    out_att_next  = '0;
                    out_cnt_next  = cnt_reg;
                    case (func_reg)
                        FN_ADD: begin
                            out_res_next = EV_ADDED;
                            mem_wd.id    = id_reg;
                            mem_wd.stamp = now_reg;
                            mem_wd.att   = '0;
                            if (hit_reg) begin
                                mem_we = 1'b1;
                                mem_wa = hit_idx_reg;
                            end else if (free_reg) begin
                                mem_we                   = 1'b1;
                                mem_wa                   = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                cnt_next                 = cnt_reg + CNT_W'(1);
                                out_cnt_next             = cnt_reg + CNT_W'(1);
                            end else begin
                                out_res_next = EV_FULL;
                            end
                        end
                        FN_CONFIRM: begin
                            if (hit_reg) begin
                                valid_next[hit_idx_reg] = 1'b0;
                                cnt_next     = cnt_reg - CNT_W'(1);
                                out_cnt_next = cnt_reg - CNT_W'(1);
                                out_res_next = EV_CONFIRMED;
                            end else begin
                                out_res_next = EV_NOT_PENDING;
                            end
                        end
                        FN_QUERY: begin
                            if (hit_reg) begin
                                out_res_next = EV_PRESENT;
                                out_att_next = hit_att_reg;
                            end else begin
                                out_res_next = EV_NOT_PENDING;
                            end
                        end
                        FN_SCAN: begin
                            out_res_next = EV_SCAN_DONE;
                            out_id_next  = '0;
                        end
                        FN_CLEAR: begin
                            valid_next   = '0;
                            cnt_next     = '0;
                            out_cnt_next = '0;
                            out_res_next = EV_CLEARED;
                            out_id_next  = '0;
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_slot_reg <= slot_mem[a_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= TIMEOUT_RST;
            retries_reg   <= RETRIES_RST;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            a_busy_reg    <= 1'b0;
            b_busy_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            timeout_reg   <= timeout_next;
            retries_reg   <= retries_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            a_busy_reg    <= a_busy_next;
            b_busy_reg    <= b_busy_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        id_reg        <= id_next;
        now_reg       <= now_next;
        a_idx_reg     <= a_idx_next;
        b_idx_reg     <= b_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_att_reg   <= hit_att_next;
        free_idx_reg  <= free_idx_next;
        out_res_reg   <= out_res_next;
        out_id_reg    <= out_id_next;
        out_att_reg   <= out_att_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    // pending count tracks the valid bits through every add, confirm, drop and clear
    `ASSERT_IMPLIES(a_cnt_matches_valid, 1'b1, ($countones(valid_reg) == int'(cnt_reg)))

    // a known operation always starts the sequencer
    `ASSERT_NEXT(a_known_func_leaves_idle, (s_tvalid && s_tready && (s_tuser <= FN_CLEAR)), (state_reg != ST_IDLE))

    // a cleared result leaves the table empty
    `ASSERT_NEXT(a_clear_empties, (out_load && out_res_next == EV_CLEARED), (valid_reg == '0))

endmodule

`default_nettype wire
